// File: rtl/core/sgwe_pkg.sv
// Shared types and codes for the stack graph walk engine.
// Used by every module of the engine; depends on nothing else.
package sgwe_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PAST_END = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    typedef enum logic [1:0] {
        COLOR_WHITE = 2'd0,
        COLOR_GRAY  = 2'd1,
        COLOR_BLACK = 2'd2
    } color_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_CHECK,
        S_RESTART,
        S_POP,
        S_COUNT,
        S_COLOR,
        S_CHECK,
        S_BLACK,
        S_TOP,
        S_RESPOND
    } seq_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] edge_source;
        logic [7:0] edge_target;
    } sgwe_in_t;

    typedef struct packed {
        logic [7:0] current_vertex;
        logic       walk_done;
        logic [1:0] status;
    } sgwe_out_t;

    // Strobes toward the graph store.
    typedef struct packed {
        logic count_rd;
        logic count_wr;
        logic edge_rd;
        logic edge_wr;
    } graph_ctl_t;

    // Strobes toward the walk store.
    typedef struct packed {
        logic   color_rd;
        logic   color_wr;
        color_t color_val;
        logic   color_clear;
        logic   stack_rd;
        logic   stack_wr;
    } walk_ctl_t;

endpackage

// File: rtl/core/sgwe_graph_store.sv
// Graph storage: per-vertex edge lists and their fill counts.
// Depends on sgwe_pkg for the control struct.
module sgwe_graph_store import sgwe_pkg::*; #(
    parameter int VN = 256,
    parameter int MD = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  graph_ctl_t                    ctl,
    input  logic [$clog2(VN)-1:0]         count_addr,
    input  logic [$clog2(MD+1)-1:0]       count_wdata,
    output logic [$clog2(MD+1)-1:0]       count_rdata,
    input  logic [$clog2(VN*MD)-1:0]      edge_addr,
    input  logic [7:0]                    edge_wdata,
    output logic [7:0]                    edge_rdata
);

    localparam int CW = $clog2(MD + 1);
    localparam int ED = VN * MD;

    logic [CW-1:0] count_mem [VN];
    logic [VN-1:0] count_vld_reg;
    logic [CW-1:0] count_rdata_reg;
    logic [7:0]    edge_mem [ED];
    logic [7:0]    edge_rdata_reg;

    // A count that was never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_vld_reg <= '0;
        end else if (ctl.count_wr) begin
            count_vld_reg[count_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.count_wr) begin
            count_mem[count_addr] <= count_wdata;
        end
        if (ctl.count_rd) begin
            count_rdata_reg <= count_vld_reg[count_addr] ? count_mem[count_addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.edge_wr) begin
            edge_mem[edge_addr] <= edge_wdata;
        end
        if (ctl.edge_rd) begin
            edge_rdata_reg <= edge_mem[edge_addr];
        end
    end

    assign count_rdata = count_rdata_reg;
    assign edge_rdata  = edge_rdata_reg;

endmodule

// File: rtl/core/sgwe_walk_store.sv
// Walk storage: vertex colors with per-vertex valid bits, and the walk stack.
// Depends on sgwe_pkg for the control struct and color type.
module sgwe_walk_store import sgwe_pkg::*; #(
    parameter int VN = 256,
    parameter int SD = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  walk_ctl_t             ctl,
    input  logic [$clog2(VN)-1:0] color_addr,
    output color_t                color_rdata,
    input  logic [$clog2(SD)-1:0] stack_addr,
    input  logic [7:0]            stack_wdata,
    output logic [7:0]            stack_rdata
);

    color_t        color_mem [VN];
    logic [VN-1:0] color_vld_reg;
    color_t        color_rdata_reg;
    logic [7:0]    stack_mem [SD];
    logic [7:0]    stack_rdata_reg;

    // Clearing the valid bits turns every vertex white.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_vld_reg <= '0;
        end else if (ctl.color_clear) begin
            color_vld_reg <= '0;
        end else if (ctl.color_wr) begin
            color_vld_reg[color_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.color_wr) begin
            color_mem[color_addr] <= ctl.color_val;
        end
        if (ctl.color_rd) begin
            color_rdata_reg <= color_vld_reg[color_addr] ? color_mem[color_addr]
                                                         : COLOR_WHITE;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.stack_wr) begin
            stack_mem[stack_addr] <= stack_wdata;
        end
        if (ctl.stack_rd) begin
            stack_rdata_reg <= stack_mem[stack_addr];
        end
    end

    assign color_rdata = color_rdata_reg;
    assign stack_rdata = stack_rdata_reg;

endmodule

// File: rtl/core/sgwe_seq.sv
// Sequencer of the walk engine: request decode, edge scan loop, stack pointer.
// Depends on sgwe_pkg; drives sgwe_graph_store and sgwe_walk_store.
module sgwe_seq import sgwe_pkg::*; #(
    parameter int VN = 256,
    parameter int MD = 8,
    parameter int SD = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [8:0]                    cfg_wr_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  sgwe_in_t                      req,
    output logic                          res_valid,
    input  logic                          res_free,
    output sgwe_out_t                     res,
    output graph_ctl_t                    gctl,
    output logic [$clog2(VN)-1:0]         count_addr,
    output logic [$clog2(MD+1)-1:0]       count_wdata,
    input  logic [$clog2(MD+1)-1:0]       count_rdata,
    output logic [$clog2(VN*MD)-1:0]      edge_addr,
    output logic [7:0]                    edge_wdata,
    input  logic [7:0]                    edge_rdata,
    output walk_ctl_t                     wctl,
    output logic [$clog2(VN)-1:0]         color_addr,
    input  color_t                        color_rdata,
    output logic [$clog2(SD)-1:0]         stack_addr,
    output logic [7:0]                    stack_wdata,
    input  logic [7:0]                    stack_rdata
);

    localparam int VAW = $clog2(VN);
    localparam int CW  = $clog2(MD + 1);
    localparam int EAW = $clog2(VN * MD);
    localparam int SAW = $clog2(SD);
    localparam int DW  = $clog2(SD + 1);
    localparam logic [8:0]    VN_LIM = 9'(VN);
    localparam logic [CW-1:0] MD_LIM = CW'(MD);
    localparam logic [DW-1:0] SD_LIM = DW'(SD);

    seq_state_t    state_reg, state_next;
    logic [8:0]    vcount_reg;
    logic [7:0]    src_reg, src_next;
    logic [7:0]    dst_reg, dst_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [7:0]    top_reg, top_next;
    logic [VAW-1:0] cur_reg, cur_next;
    logic [VAW-1:0] nb_reg, nb_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [CW-1:0] n_reg, n_next;
    logic [1:0]    status_reg, status_next;

    logic          load_ok;
    logic [CW-1:0] slot_inc;
    logic [DW-1:0] depth_dec;
    logic [EAW-1:0] cur_base;

    assign load_ok = ({1'b0, src_reg} < vcount_reg) && ({1'b0, dst_reg} < vcount_reg) &&
                     ({1'b0, src_reg} < VN_LIM) && ({1'b0, dst_reg} < VN_LIM) &&
                     (count_rdata < MD_LIM);
    assign slot_inc  = slot_reg + 1'b1;
    assign depth_dec = depth_reg - 1'b1;
    assign cur_base  = EAW'(cur_reg) * EAW'(MD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            vcount_reg <= '0;
            depth_reg  <= '0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        top_reg    <= top_next;
        cur_reg    <= cur_next;
        nb_reg     <= nb_next;
        slot_reg   <= slot_next;
        n_reg      <= n_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        cur_next    = cur_reg;
        nb_next     = nb_reg;
        slot_next   = slot_reg;
        n_next      = n_reg;
        status_next = status_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        gctl        = '0;
        wctl        = '0;
        wctl.color_val = COLOR_WHITE;
        count_addr  = src_reg[VAW-1:0];
        count_wdata = count_rdata + 1'b1;
        edge_addr   = cur_base + EAW'(slot_reg);
        edge_wdata  = dst_reg;
        color_addr  = nb_reg;
        stack_addr  = depth_reg[SAW-1:0];
        stack_wdata = 8'(nb_reg);

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    src_next    = req.edge_source;
                    dst_next    = req.edge_target;
                    status_next = ST_OK;
                    case (req.operation)
                        OP_LOAD: begin
                            gctl.count_rd = 1'b1;
                            count_addr    = req.edge_source[VAW-1:0];
                            state_next    = S_LOAD_CHECK;
                        end
                        OP_RESTART: begin
                            state_next = S_RESTART;
                        end
                        OP_ADVANCE: begin
                            if (depth_reg == '0) begin
                                status_next = ST_PAST_END;
                                state_next  = S_RESPOND;
                            end else begin
                                state_next = S_POP;
                            end
                        end
                        default: begin
                            state_next = S_RESPOND;
                        end
                    endcase
                end
            end
            S_LOAD_CHECK: begin
                if (load_ok) begin
                    gctl.count_wr = 1'b1;
                    gctl.edge_wr  = 1'b1;
                    edge_addr     = EAW'(src_reg[VAW-1:0]) * EAW'(MD) + EAW'(count_rdata);
                end else begin
                    status_next = ST_REJECTED;
                end
                state_next = S_RESPOND;
            end
            S_RESTART: begin
                wctl.color_clear = 1'b1;
                if (vcount_reg != '0) begin
                    wctl.stack_wr = 1'b1;
                    stack_addr    = '0;
                    stack_wdata   = '0;
                    depth_next    = DW'(1);
                    top_next      = '0;
                end else begin
                    depth_next = '0;
                end
                state_next = S_RESPOND;
            end
            S_POP: begin
                cur_next      = top_reg[VAW-1:0];
                depth_next    = depth_dec;
                gctl.count_rd = 1'b1;
                count_addr    = top_reg[VAW-1:0];
                state_next    = S_COUNT;
            end
            S_COUNT: begin
                n_next    = count_rdata;
                slot_next = '0;
                if (count_rdata == '0) begin
                    state_next = S_BLACK;
                end else begin
                    gctl.edge_rd = 1'b1;
                    edge_addr    = cur_base;
                    state_next   = S_COLOR;
                end
            end
            S_COLOR: begin
                nb_next       = edge_rdata[VAW-1:0];
                wctl.color_rd = 1'b1;
                color_addr    = edge_rdata[VAW-1:0];
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                // A white neighbor turns gray even when the stack has no room.
                if (color_rdata == COLOR_WHITE) begin
                    wctl.color_wr  = 1'b1;
                    wctl.color_val = COLOR_GRAY;
                    if (depth_reg < SD_LIM) begin
                        wctl.stack_wr = 1'b1;
                        depth_next    = depth_reg + 1'b1;
                        top_next      = 8'(nb_reg);
                    end
                end
                slot_next = slot_inc;
                if (slot_inc == n_reg) begin
                    state_next = S_BLACK;
                end else begin
                    gctl.edge_rd = 1'b1;
                    edge_addr    = cur_base + EAW'(slot_inc);
                    state_next   = S_COLOR;
                end
            end
            S_BLACK: begin
                wctl.color_wr  = 1'b1;
                wctl.color_val = COLOR_BLACK;
                color_addr     = cur_reg;
                if (depth_reg != '0) begin
                    wctl.stack_rd = 1'b1;
                    stack_addr    = depth_dec[SAW-1:0];
                    state_next    = S_TOP;
                end else begin
                    state_next = S_RESPOND;
                end
            end
            S_TOP: begin
                top_next   = stack_rdata;
                state_next = S_RESPOND;
            end
            S_RESPOND: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.current_vertex = (depth_reg == '0) ? 8'd0 : top_reg;
    assign res.walk_done      = (depth_reg == '0);
    assign res.status         = status_reg;

endmodule

// File: rtl/core/stack_graph_walk_engine_unit.sv
// Depth-first walk engine: load edges, restart and advance a stack-based walk.
// One request at a time; the next is taken the cycle after the result enters
// the output register. The edge loop reads each edge and then its neighbor's
// color on the single-port edge and color memories. Reset (aresetn, synchronous,
// active low) clears control state, edge counts and colors at once through valid bits.
module stack_graph_walk_engine_unit import sgwe_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DEGREE   = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  sgwe_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sgwe_out_t m_data
);

    // Vertex numbers arrive on 8-bit fields, so at most 256 vertices are reachable;
    // with a self-loop on the start vertex the stack can hold one entry more.
    localparam int VN  = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int SD  = (MAX_VERTICES < 257) ? MAX_VERTICES : 257;
    localparam int VAW = $clog2(VN);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int EAW = $clog2(VN * MAX_DEGREE);
    localparam int SAW = $clog2(SD);

    graph_ctl_t     gctl;
    walk_ctl_t      wctl;
    logic [VAW-1:0] count_addr;
    logic [CW-1:0]  count_wdata;
    logic [CW-1:0]  count_rdata;
    logic [EAW-1:0] edge_addr;
    logic [7:0]     edge_wdata;
    logic [7:0]     edge_rdata;
    logic [VAW-1:0] color_addr;
    color_t         color_rdata;
    logic [SAW-1:0] stack_addr;
    logic [7:0]     stack_wdata;
    logic [7:0]     stack_rdata;
    logic           res_valid;
    logic           res_free;
    sgwe_out_t      res;
    logic           m_valid_reg;
    sgwe_out_t      m_data_reg;

    sgwe_seq #(.VN(VN), .MD(MAX_DEGREE), .SD(SD)) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_data),
        .res_valid   (res_valid),
        .res_free    (res_free),
        .res         (res),
        .gctl        (gctl),
        .count_addr  (count_addr),
        .count_wdata (count_wdata),
        .count_rdata (count_rdata),
        .edge_addr   (edge_addr),
        .edge_wdata  (edge_wdata),
        .edge_rdata  (edge_rdata),
        .wctl        (wctl),
        .color_addr  (color_addr),
        .color_rdata (color_rdata),
        .stack_addr  (stack_addr),
        .stack_wdata (stack_wdata),
        .stack_rdata (stack_rdata)
    );

    sgwe_graph_store #(.VN(VN), .MD(MAX_DEGREE)) u_graph (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (gctl),
        .count_addr  (count_addr),
        .count_wdata (count_wdata),
        .count_rdata (count_rdata),
        .edge_addr   (edge_addr),
        .edge_wdata  (edge_wdata),
        .edge_rdata  (edge_rdata)
    );

    sgwe_walk_store #(.VN(VN), .SD(SD)) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (wctl),
        .color_addr  (color_addr),
        .color_rdata (color_rdata),
        .stack_addr  (stack_addr),
        .stack_wdata (stack_wdata),
        .stack_rdata (stack_rdata)
    );

    // Output register: a new result may enter as the held one leaves.
    assign res_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/sgwe_checker.sv
// Port-level checks for the walk engine, bound to the top level.
// Depends on sgwe_pkg and stack_graph_walk_engine_unit.
module sgwe_checker import sgwe_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input sgwe_out_t m_data
);

    // A held result must not change before it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The engine works on one request at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // An empty stack always reports vertex zero.
    a_done_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.walk_done |-> m_data.current_vertex == 8'd0)
        else $error("finished walk reports a vertex");

    // Advancing past the end leaves the walk finished.
    a_past_end_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_PAST_END |-> m_data.walk_done)
        else $error("past-end status on an open walk");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == ST_OK || m_data.status == ST_PAST_END ||
                    m_data.status == ST_REJECTED)
        else $error("unknown status code");

endmodule

bind stack_graph_walk_engine_unit sgwe_checker u_sgwe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: test/sgwe_walk_checker.sv
// Checker for the stack graph walk engine: watches both channels and the config port.
// Predicts each result from its own graph, color and stack state and compares fields.
// Depends on sgwe_pkg for the payload types and the operation and status codes.
`timescale 1ns / 100ps

module sgwe_walk_checker import sgwe_pkg::*; #(
    parameter int MAX_V = 256,
    parameter int MAX_D = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  sgwe_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  sgwe_out_t m_data,
    output int        open_count,
    output int        fail_count,
    output int        rejected_loads,
    output int        past_end_steps,
    output int        walks_finished
);

    logic [7:0]  adj [MAX_V][MAX_D];
    int unsigned out_deg [MAX_V];
    color_t      shade [MAX_V];
    logic [7:0]  dfs_stack [MAX_V];
    int unsigned depth;
    logic [8:0]  vtx_limit;

    sgwe_out_t   replies_due [$];

    function automatic void push_vertex(logic [7:0] v);
        // A push onto a full stack is dropped.
        if (depth < MAX_V) begin
            dfs_stack[depth] = v;
            depth++;
        end
    endfunction

    function automatic sgwe_out_t predict_walk_step(sgwe_in_t req);
        sgwe_out_t  res;
        logic [7:0] cur;
        logic [7:0] nb;
        res.status = ST_OK;
        case (req.operation)
            OP_LOAD: begin
                if ({1'b0, req.edge_source} >= vtx_limit ||
                    {1'b0, req.edge_target} >= vtx_limit ||
                    out_deg[req.edge_source] >= MAX_D) begin
                    res.status = ST_REJECTED;
                end else begin
                    adj[req.edge_source][out_deg[req.edge_source]] = req.edge_target;
                    out_deg[req.edge_source]++;
                end
            end
            OP_RESTART: begin
                foreach (shade[i]) shade[i] = COLOR_WHITE;
                depth = 0;
                // Vertex 0 goes on the stack while still white.
                if (vtx_limit != 0) push_vertex(8'd0);
            end
            OP_ADVANCE: begin
                if (depth == 0) begin
                    res.status = ST_PAST_END;
                end else begin
                    depth--;
                    cur = dfs_stack[depth];
                    for (int i = 0; i < out_deg[cur]; i++) begin
                        nb = adj[cur][i];
                        if (shade[nb] == COLOR_WHITE) begin
                            push_vertex(nb);
                            shade[nb] = COLOR_GRAY;
                        end
                    end
                    shade[cur] = COLOR_BLACK;
                end
            end
            default: ;
        endcase
        if (depth == 0) begin
            res.current_vertex = 8'd0;
            res.walk_done      = 1'b1;
        end else begin
            res.current_vertex = dfs_stack[depth - 1];
            res.walk_done      = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        sgwe_out_t due;
        if (!aresetn) begin
            foreach (out_deg[i]) out_deg[i] = 0;
            foreach (shade[i]) shade[i] = COLOR_WHITE;
            depth          = 0;
            vtx_limit      = 9'd0;
            fail_count     = 0;
            rejected_loads = 0;
            past_end_steps = 0;
            walks_finished = 0;
            replies_due.delete();
            open_count <= 0;
        end else begin
            if (cfg_wr_en) vtx_limit = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result arrived with no request waiting for it");
                    fail_count++;
                end else begin
                    due = replies_due.pop_front();
                    if (m_data.current_vertex !== due.current_vertex) begin
                        $error("current_vertex: expected %0d, got %0d",
                               due.current_vertex, m_data.current_vertex);
                        fail_count++;
                    end
                    if (m_data.walk_done !== due.walk_done) begin
                        $error("walk_done: expected %0d, got %0d",
                               due.walk_done, m_data.walk_done);
                        fail_count++;
                    end
                    if (m_data.status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, m_data.status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                due = predict_walk_step(s_data);
                if (due.status == ST_REJECTED) rejected_loads++;
                if (due.status == ST_PAST_END) past_end_steps++;
                if (s_data.operation == OP_ADVANCE && due.status == ST_OK && due.walk_done)
                    walks_finished++;
                replies_due = {replies_due, due};
            end
            // Registered so the stimulus side reads it without a race.
            open_count <= replies_due.size();
        end
    end

endmodule

// File: test/tb.sv
// Top of the walk engine testbench: clock, reset, request and result traffic, verdict.
// Instantiates stack_graph_walk_engine_unit and sgwe_walk_checker; uses sgwe_pkg types.
`timescale 1ns / 100ps

module tb;
    import sgwe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS       = 1300;
    localparam int STALL_LIMIT = 3000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [8:0] cfg_wr_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sgwe_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sgwe_out_t m_data;

    int open_count;
    int fail_count;
    int rejected_loads;
    int past_end_steps;
    int walks_finished;

    int sent = 0;
    int settings_used = 0;
    int rx_seen = 0;
    int rx_gap = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    stack_graph_walk_engine_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    sgwe_walk_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .open_count     (open_count),
        .fail_count     (fail_count),
        .rejected_loads (rejected_loads),
        .past_end_steps (past_end_steps),
        .walks_finished (walks_finished)
    );

    // Result side: a random hold-off after each result, stretches without one,
    // and one long hold-off that backs the engine up into its request port.
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (rx_seen == 700)
                gap = 500;
            else if ((rx_seen / 64) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 13);
            rx_seen <= rx_seen + 1;
            rx_gap  <= gap;
            m_ready <= (gap == 0);
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= (rx_gap == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] src, input logic [7:0] dst);
        int gap;
        gap = ((sent / 50) % 4 == 1) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{operation: op, edge_source: src, edge_target: dst};
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // The register is only written once every result has come back.
    task automatic set_vertex_count(input logic [8:0] count);
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_count != 0);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_vertex(input logic [8:0] count);
        return (count == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, count - 1));
    endfunction

    initial begin
        logic [8:0] vcount;
        int loads;
        int steps;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty graph: every load is rejected and a restart is done at once.
        set_vertex_count(9'd0);
        send(OP_ADVANCE, 8'd0, 8'd0);
        send(OP_RESTART, 8'd0, 8'd0);
        send(OP_LOAD, 8'd0, 8'd0);
        send(OP_UNUSED, 8'hFF, 8'hFF);

        // Full range: a self-loop on the start vertex, a full edge list on the
        // last vertex, then a walk that pops vertex 0 a second time when black.
        set_vertex_count(9'd256);
        send(OP_LOAD, 8'd0, 8'd0);
        send(OP_LOAD, 8'd0, 8'd255);
        repeat (8) send(OP_LOAD, 8'd255, 8'd255);
        send(OP_LOAD, 8'd255, 8'd0);
        send(OP_RESTART, 8'hFF, 8'hFF);
        repeat (4) send(OP_ADVANCE, 8'hFF, 8'h00);

        // Source and target each just out of range.
        set_vertex_count(9'd5);
        send(OP_LOAD, 8'd5, 8'd0);
        send(OP_LOAD, 8'd0, 8'd5);

        while (sent < ITEMS) begin
            case ($urandom_range(0, 9))
                0:       vcount = 9'd0;
                1:       vcount = 9'd1;
                2:       vcount = 9'd2;
                3:       vcount = 9'd256;
                4:       vcount = 9'd255;
                default: vcount = 9'($urandom_range(3, 48));
            endcase
            set_vertex_count(vcount);
            loads = $urandom_range(0, 24);
            repeat (loads) begin
                if ($urandom_range(0, 9) == 0)
                    send(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                else
                    send(OP_LOAD, pick_vertex(vcount), pick_vertex(vcount));
            end
            send(OP_RESTART, 8'($urandom), 8'($urandom));
            steps = $urandom_range(1, loads + 8);
            repeat (steps) begin
                if ($urandom_range(0, 15) == 0)
                    send(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                else
                    send(OP_ADVANCE, 8'($urandom), 8'($urandom));
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (open_count != 0);
        repeat (25) @(posedge aclk);

        $display("Sent %0d requests over %0d vertex counts: %0d loads rejected,",
                 sent, settings_used, rejected_loads);
        $display("%0d advances past the end, %0d walks advanced to completion.",
                 past_end_steps, walks_finished);
        if (fail_count == 0 && open_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
